// ===== hw/rtl/pthc_pkg.sv =====
// ----------------------------------------------------------------------------
// pthc_pkg
// Shared types, register codes, constants and shift helpers for the
// temperature / pressure / humidity compensation pipeline.
// ----------------------------------------------------------------------------
package pthc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned DIV_W      = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CAL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_CAL_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_CAL_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_CAL_C = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HUM_CAL_A   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HUM_CAL_B   = 3'd5;

  // Compensation constants
  localparam logic [63:0] P_T_OFS   = 64'd128000;
  localparam logic [63:0] P_FULL    = 64'd1048576;
  localparam logic [63:0] P_SCALE   = 64'd3125;
  localparam logic [63:0] P_BIAS47  = 64'h0000_8000_0000_0000;
  localparam logic [31:0] H_T_OFS   = 32'd76800;
  localparam logic [31:0] H_MAX     = 32'd419430400;
  localparam logic [31:0] H_RND14   = 32'd16384;
  localparam logic [31:0] H_OFS_Y   = 32'd2097152;
  localparam logic [31:0] H_OFS_H3  = 32'd32768;
  localparam logic [31:0] H_RND_H2  = 32'd8192;
  localparam logic [31:0] T_RND     = 32'd128;

  typedef struct packed {
    logic [47:0] temp;
    logic [47:0] press_a;
    logic [47:0] press_b;
    logic [47:0] press_c;
    logic [31:0] hum_a;
    logic [39:0] hum_b;
  } cal_t;

  // Results that ride alongside the pressure division
  typedef struct packed {
    logic [31:0] temp;
    logic [16:0] hum;
  } side_t;

  function automatic logic [31:0] asr32(logic [31:0] x, int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] x, int unsigned n);
    return 64'($signed(x) >>> n);
  endfunction

endpackage

// ===== hw/rtl/pth_sensor_compensation.sv =====
// ----------------------------------------------------------------------------
// pth_sensor_compensation
// Integer compensation of raw temperature, pressure and humidity samples.
// ----------------------------------------------------------------------------
// Takes one raw sample word per cycle and returns one compensated word per
// word taken, in order, through 13 stages for temperature, humidity and the
// pressure dividend and divisor, 65 stages for the signed 64-bit division
// (a sign stage plus one quotient bit per stage), and 6 stages for the
// pressure correction and the output register. The whole
// pipeline advances together; when a finished word waits on out_stall every
// stage holds, and in_stall follows so no word is taken until it moves.
// Temperature is in 0.01 degree units, pressure in Pa as Q24.8 (pressure is
// 0 and pressure_invalid is set when the divisor works out to zero), and
// humidity in percent as Q22.10 clamped to 0..100. Calibration registers are
// written through cfg_wen / cfg_index / cfg_data, indexes 0..5 in the order
// temp_cal, press_cal_a, press_cal_b, press_cal_c, hum_cal_a, hum_cal_b;
// other indexes are dropped. Write them only with the pipeline empty.
// ----------------------------------------------------------------------------
module pth_sensor_compensation import pthc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [19:0]           raw_temperature,
  input  logic [19:0]           raw_pressure,
  input  logic [15:0]           raw_humidity,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [31:0]    temperature_centi,
  output logic [31:0]           pressure_q24_8,
  output logic                  pressure_invalid,
  output logic [16:0]           humidity_q22_10
);

  cal_t        cal;
  logic        adv;
  logic        f_valid, d_valid;
  logic [63:0] num, den, quo;
  logic        neg, zero;
  side_t       f_side, d_side;

  // Advance every stage unless the output word is held
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_TEMP_CAL:    cal.temp    <= cfg_data;
        CFG_PRESS_CAL_A: cal.press_a <= cfg_data;
        CFG_PRESS_CAL_B: cal.press_b <= cfg_data;
        CFG_PRESS_CAL_C: cal.press_c <= cfg_data;
        CFG_HUM_CAL_A:   cal.hum_a   <= cfg_data[31:0];
        CFG_HUM_CAL_B:   cal.hum_b   <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  pthc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .cal             (cal),
    .in_valid        (in_valid),
    .raw_temperature (raw_temperature),
    .raw_pressure    (raw_pressure),
    .raw_humidity    (raw_humidity),
    .f_valid         (f_valid),
    .num             (num),
    .den             (den),
    .side            (f_side)
  );

  pthc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (f_valid),
    .num      (num),
    .den      (den),
    .side     (f_side),
    .d_valid  (d_valid),
    .quo      (quo),
    .neg      (neg),
    .zero     (zero),
    .side_o   (d_side)
  );

  pthc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .adv               (adv),
    .cal               (cal),
    .d_valid           (d_valid),
    .quo               (quo),
    .neg               (neg),
    .zero              (zero),
    .side              (d_side),
    .out_valid         (out_valid),
    .temperature_centi (temperature_centi),
    .pressure_q24_8    (pressure_q24_8),
    .pressure_invalid  (pressure_invalid),
    .humidity_q22_10   (humidity_q22_10)
  );

endmodule

// ===== hw/rtl/pthc_front.sv =====
// ----------------------------------------------------------------------------
// pthc_front
// Temperature, humidity and pressure divisor / dividend stages (13 stages).
// ----------------------------------------------------------------------------
module pthc_front import pthc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  cal_t        cal,
  input  logic        in_valid,
  input  logic [19:0] raw_temperature,
  input  logic [19:0] raw_pressure,
  input  logic [15:0] raw_humidity,
  output logic        f_valid,
  output logic [63:0] num,
  output logic [63:0] den,
  output side_t       side
);

  logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
  logic [63:0] p1, p2, p3, p4, p5, p6;

  assign t1 = {16'd0, cal.temp[15:0]};
  assign t2 = {{16{cal.temp[31]}}, cal.temp[31:16]};
  assign t3 = {{16{cal.temp[47]}}, cal.temp[47:32]};
  assign p1 = {48'd0, cal.press_a[15:0]};
  assign p2 = {{48{cal.press_a[31]}}, cal.press_a[31:16]};
  assign p3 = {{48{cal.press_a[47]}}, cal.press_a[47:32]};
  assign p4 = {{48{cal.press_b[15]}}, cal.press_b[15:0]};
  assign p5 = {{48{cal.press_b[31]}}, cal.press_b[31:16]};
  assign p6 = {{48{cal.press_b[47]}}, cal.press_b[47:32]};
  assign h1 = {24'd0, cal.hum_a[7:0]};
  assign h2 = {{16{cal.hum_a[23]}}, cal.hum_a[23:8]};
  assign h3 = {24'd0, cal.hum_a[31:24]};
  assign h4 = {{16{cal.hum_b[15]}}, cal.hum_b[15:0]};
  assign h5 = {{16{cal.hum_b[31]}}, cal.hum_b[31:16]};
  assign h6 = {{24{cal.hum_b[39]}}, cal.hum_b[39:32]};

  logic [12:0] vld;

  logic [31:0] ta, td;
  assign ta = 32'(raw_temperature >> 3) - (t1 << 1);
  assign td = 32'(raw_temperature >> 4) - t1;

  logic [31:0] s1_ta_m, s1_dd;
  logic [19:0] s1_rp, s2_rp, s3_rp, s4_rp, s5_rp, s6_rp;
  logic [15:0] s1_rh, s2_rh, s3_rh;
  logic [31:0] s2_a, s2_bm, s3_tf;
  logic [31:0] s4_temp, s5_temp, s6_temp, s7_temp, s8_temp, s9_temp;
  logic [31:0] s10_temp, s11_temp, s12_temp;
  logic [63:0] s4_v1;
  logic [31:0] s4_hv, s4_xb;
  logic [63:0] s5_sq, s5_vp5, s5_vp2;
  logic [31:0] s5_xb, s5_xm, s5_vh6, s5_vh3;
  logic [63:0] s6_v2a, s6_v1a, s6_vp5, s6_vp2;
  logic [31:0] s6_x, s6_y1, s6_y2;
  logic [63:0] s7_v2, s7_v1b, s7_pn;
  logic [31:0] s7_x, s7_y;
  logic [63:0] s8_m, s8_pn2;
  logic [31:0] s8_x, s8_ym;
  logic [63:0] s9_den, s9_num, s10_den, s10_num, s11_den, s11_num, s12_den, s12_num;
  logic [31:0] s9_x, s9_yh, s10_vv, s11_vv, s11_sq, s12_vv, s12_t;

  logic [31:0] s11_s15, s13_hv, s13_hc;
  assign s11_s15 = asr32(s10_vv, 15);
  assign s13_hv  = s12_vv - asr32(s12_t, 4);

  always_comb begin
    if (s13_hv[31]) begin
      s13_hc = '0;
    end else if (s13_hv > H_MAX) begin
      s13_hc = H_MAX;
    end else begin
      s13_hc = s13_hv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[11:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // temperature
      s1_ta_m  <= ta * t2;
      s1_dd    <= td * td;
      s1_rp    <= raw_pressure;
      s1_rh    <= raw_humidity;

      s2_a     <= asr32(s1_ta_m, 11);
      s2_bm    <= asr32(s1_dd, 12) * t3;
      s2_rp    <= s1_rp;
      s2_rh    <= s1_rh;

      s3_tf    <= s2_a + asr32(s2_bm, 14);
      s3_rp    <= s2_rp;
      s3_rh    <= s2_rh;

      s4_temp  <= asr32((s3_tf << 2) + s3_tf + T_RND, 8);
      s4_v1    <= {{32{s3_tf[31]}}, s3_tf} - P_T_OFS;
      s4_hv    <= s3_tf - H_T_OFS;
      s4_xb    <= (32'(s3_rh) << 14) - (h4 << 20) + H_RND14;
      s4_rp    <= s3_rp;

      // pressure and humidity side by side
      s5_temp  <= s4_temp;
      s5_sq    <= s4_v1 * s4_v1;
      s5_vp5   <= s4_v1 * p5;
      s5_vp2   <= s4_v1 * p2;
      s5_rp    <= s4_rp;
      s5_xb    <= s4_xb;
      s5_xm    <= h5 * s4_hv;
      s5_vh6   <= s4_hv * h6;
      s5_vh3   <= s4_hv * h3;

      s6_temp  <= s5_temp;
      s6_v2a   <= s5_sq * p6;
      s6_v1a   <= s5_sq * p3;
      s6_vp5   <= s5_vp5;
      s6_vp2   <= s5_vp2;
      s6_rp    <= s5_rp;
      s6_x     <= asr32(s5_xb - s5_xm, 15);
      s6_y1    <= asr32(s5_vh6, 10);
      s6_y2    <= asr32(s5_vh3, 11) + H_OFS_H3;

      s7_temp  <= s6_temp;
      s7_v2    <= s6_v2a + (s6_vp5 << 17) + (p4 << 35);
      s7_v1b   <= asr64(s6_v1a, 8) + (s6_vp2 << 12) + P_BIAS47;
      s7_pn    <= (P_FULL - 64'(s6_rp)) << 31;
      s7_x     <= s6_x;
      s7_y     <= s6_y1 * s6_y2;

      s8_temp  <= s7_temp;
      s8_m     <= s7_v1b * p1;
      s8_pn2   <= s7_pn - s7_v2;
      s8_x     <= s7_x;
      s8_ym    <= (asr32(s7_y, 10) + H_OFS_Y) * h2;

      s9_temp  <= s8_temp;
      s9_den   <= asr64(s8_m, 33);
      s9_num   <= s8_pn2 * P_SCALE;
      s9_x     <= s8_x;
      s9_yh    <= asr32(s8_ym + H_RND_H2, 14);

      // humidity tail; hold divider operands
      s10_temp <= s9_temp;
      s10_den  <= s9_den;
      s10_num  <= s9_num;
      s10_vv   <= s9_x * s9_yh;

      s11_temp <= s10_temp;
      s11_den  <= s10_den;
      s11_num  <= s10_num;
      s11_vv   <= s10_vv;
      s11_sq   <= s11_s15 * s11_s15;

      s12_temp <= s11_temp;
      s12_den  <= s11_den;
      s12_num  <= s11_num;
      s12_vv   <= s11_vv;
      s12_t    <= asr32(s11_sq, 7) * h1;

      side.temp <= s12_temp;
      side.hum  <= s13_hc[28:12];
      den       <= s12_den;
      num       <= s12_num;
    end
  end

  assign f_valid = vld[12];

endmodule

// ===== hw/rtl/pthc_div.sv =====
// ----------------------------------------------------------------------------
// pthc_div
// Pipelined 64-bit restoring divider on magnitudes: one sign stage, then
// one quotient bit per stage. Side results travel with each word.
// ----------------------------------------------------------------------------
module pthc_div import pthc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_valid,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  input  side_t            side,
  output logic             d_valid,
  output logic [DIV_W-1:0] quo,
  output logic             neg,
  output logic             zero,
  output side_t            side_o
);

  logic             d0_vld, d0_neg, d0_zero;
  logic [DIV_W-1:0] d0_un, d0_ud;
  side_t            d0_side;

  logic             r_vld  [DIV_W];
  logic             r_neg  [DIV_W];
  logic             r_zero [DIV_W];
  logic [DIV_W-1:0] r_rem  [DIV_W];
  logic [DIV_W-1:0] r_quo  [DIV_W];
  logic [DIV_W-1:0] r_dv   [DIV_W];
  side_t            r_side [DIV_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      d0_vld <= 1'b0;
    end else if (adv) begin
      d0_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d0_un   <= num[DIV_W-1] ? '0 - num : num;
      d0_ud   <= den[DIV_W-1] ? '0 - den : den;
      d0_neg  <= num[DIV_W-1] ^ den[DIV_W-1];
      d0_zero <= (den == '0);
      d0_side <= side;
    end
  end

  for (genvar gi = 0; gi < DIV_W; gi++) begin : g_step
    logic             vld_in, neg_in, zero_in, ge;
    logic [DIV_W-1:0] rem_in, quo_in, dv_in;
    side_t            side_in;
    logic [DIV_W:0]   trial;

    if (gi == 0) begin : g_first
      assign vld_in  = d0_vld;
      assign neg_in  = d0_neg;
      assign zero_in = d0_zero;
      assign rem_in  = '0;
      assign quo_in  = d0_un;
      assign dv_in   = d0_ud;
      assign side_in = d0_side;
    end else begin : g_next
      assign vld_in  = r_vld[gi-1];
      assign neg_in  = r_neg[gi-1];
      assign zero_in = r_zero[gi-1];
      assign rem_in  = r_rem[gi-1];
      assign quo_in  = r_quo[gi-1];
      assign dv_in   = r_dv[gi-1];
      assign side_in = r_side[gi-1];
    end

    // Shift in the next dividend bit and try the subtract
    assign trial = {rem_in, quo_in[DIV_W-1]};
    assign ge    = (trial >= {1'b0, dv_in});

    always_ff @(posedge clk) begin
      if (rst) begin
        r_vld[gi] <= 1'b0;
      end else if (adv) begin
        r_vld[gi] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        r_rem[gi]  <= ge ? DIV_W'(trial - {1'b0, dv_in}) : trial[DIV_W-1:0];
        r_quo[gi]  <= {quo_in[DIV_W-2:0], ge};
        r_dv[gi]   <= dv_in;
        r_neg[gi]  <= neg_in;
        r_zero[gi] <= zero_in;
        r_side[gi] <= side_in;
      end
    end
  end

  assign d_valid = r_vld[DIV_W-1];
  assign quo     = r_quo[DIV_W-1];
  assign neg     = r_neg[DIV_W-1];
  assign zero    = r_zero[DIV_W-1];
  assign side_o  = r_side[DIV_W-1];

endmodule

// ===== hw/rtl/pthc_back.sv =====
// ----------------------------------------------------------------------------
// pthc_back
// Pressure tail: quotient sign, second-order correction, Q24.8 output, and
// the output register (6 stages).
// ----------------------------------------------------------------------------
module pthc_back import pthc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  cal_t               cal,
  input  logic               d_valid,
  input  logic [63:0]        quo,
  input  logic               neg,
  input  logic               zero,
  input  side_t              side,
  output logic               out_valid,
  output logic signed [31:0] temperature_centi,
  output logic [31:0]        pressure_q24_8,
  output logic               pressure_invalid,
  output logic [16:0]        humidity_q22_10
);

  logic [63:0] p7, p8, p9;
  assign p7 = {{48{cal.press_c[15]}}, cal.press_c[15:0]};
  assign p8 = {{48{cal.press_c[31]}}, cal.press_c[31:16]};
  assign p9 = {{48{cal.press_c[47]}}, cal.press_c[47:32]};

  logic [4:0]  vld;
  logic [63:0] b1_p, b2_p, b3_p, b4_p;
  logic [63:0] b2_ll, b2_w2m, b3_aa, b3_w2, b4_w1m, b4_w2, b5_s;
  logic [31:0] b2_lh;
  logic        b1_inv, b2_inv, b3_inv, b4_inv, b5_inv;
  side_t       b1_side, b2_side, b3_side, b4_side, b5_side;
  logic [63:0] b1_a, b6_pf;

  assign b1_a  = asr64(b1_p, 13);
  assign b6_pf = asr64(b5_s, 8) + (p7 << 4);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[3:0], d_valid};
      out_valid <= vld[4];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_p    <= neg ? '0 - quo : quo;
      b1_inv  <= zero;
      b1_side <= side;

      // square of p>>13 modulo 2^64 from 32-bit halves
      b2_ll   <= {32'd0, b1_a[31:0]} * {32'd0, b1_a[31:0]};
      b2_lh   <= b1_a[31:0] * b1_a[63:32];
      b2_w2m  <= p8 * b1_p;
      b2_p    <= b1_p;
      b2_inv  <= b1_inv;
      b2_side <= b1_side;

      b3_aa   <= b2_ll + {b2_lh[30:0], 33'd0};
      b3_w2   <= asr64(b2_w2m, 19);
      b3_p    <= b2_p;
      b3_inv  <= b2_inv;
      b3_side <= b2_side;

      b4_w1m  <= p9 * b3_aa;
      b4_w2   <= b3_w2;
      b4_p    <= b3_p;
      b4_inv  <= b3_inv;
      b4_side <= b3_side;

      b5_s    <= b4_p + asr64(b4_w1m, 25) + b4_w2;
      b5_inv  <= b4_inv;
      b5_side <= b4_side;

      temperature_centi <= b5_side.temp;
      humidity_q22_10   <= b5_side.hum;
      pressure_invalid  <= b5_inv;
      pressure_q24_8    <= b5_inv ? '0 : b6_pf[31:0];
    end
  end

endmodule

// ===== hw/rtl/pthc_checker.sv =====
// ----------------------------------------------------------------------------
// pthc_checker
// Port-level checks on the compensation block, bound to the top level.
// ----------------------------------------------------------------------------
module pthc_checker import pthc_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  cfg_wen,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [19:0]           raw_temperature,
  input logic [19:0]           raw_pressure,
  input logic [15:0]           raw_humidity,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic signed [31:0]    temperature_centi,
  input logic [31:0]           pressure_q24_8,
  input logic                  pressure_invalid,
  input logic [16:0]           humidity_q22_10
);

  // Input is held back only while a finished word waits
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow the held output word");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && pressure_invalid |-> pressure_q24_8 == 32'd0)
    else $error("invalid pressure word is not zero");

  a_hum_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> humidity_q22_10 <= 17'd102400)
    else $error("humidity above full scale");

endmodule

bind pth_sensor_compensation pthc_checker u_pthc_checker (.*);
